>>> hdl/tfc_pkg.sv
// Shared types, codes and constants of the transform matrix composer.
`default_nettype none

package tfc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_IDENT = 3'd0;
  localparam logic [2:0] MODE_SCALE = 3'd1;
  localparam logic [2:0] MODE_ROT   = 3'd2;
  localparam logic [2:0] MODE_TRANS = 3'd3;
  localparam logic [2:0] MODE_PERSP = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_IDENT,
    OP_OM_SCALE,
    OP_OM_TRANS,
    OP_OM_ROT,
    OP_OM_PERSP,
    OP_DIV_START,
    OP_DIV_SAVE,
    OP_MUL_START,
    OP_STORE,
    OP_COPY
  } dp_op_t;

  // rotation axis, or the halved field angle of the perspective
  typedef enum logic [1:0] {
    SEL_Z,
    SEL_X,
    SEL_Y,
    SEL_P
  } rsel_t;

  typedef enum logic [1:0] {
    DV_ANGLE,
    DV_TAN,
    DV_TB,
    DV_PERSP
  } dsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_MOD,
    S_MODW,
    S_CORW,
    S_ROTOM,
    S_DGO,
    S_DWAIT,
    S_POM,
    S_MSTART,
    S_MULW,
    S_STORE,
    S_COPY,
    S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    rsel_t      rsel;
    dsel_t      dsel;
    logic [3:0] ridx;
    logic [3:0] oidx;
    logic [3:0] widx;
    logic       clr;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       fault;
    logic [2:0] mode;
  } stat_t;

  // CORDIC arctangent of 2^-i in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd843314857;
      5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043837;
      5'd3: v = 30'd133525159;
      5'd4: v = 30'd67021687;
      5'd5: v = 30'd33543516;
      5'd6: v = 30'd16775851;
      5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194283;
      5'd9: v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tfc_if.sv
// Valid/ready channel interfaces for operation words and element words.
`default_nettype none

interface tfc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [31:0] op_c;
  logic signed [31:0] op_d;
  modport source(output valid, mode, op_a, op_b, op_c, op_d, input ready);
  modport sink(input valid, mode, op_a, op_b, op_c, op_d, output ready);
endinterface

interface tfc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] value;
  logic               last;
  logic               fault;
  modport source(output valid, row, col, value, last, fault, input ready);
  modport sink(input valid, row, col, value, last, fault, output ready);
endinterface

`default_nettype wire

>>> hdl/tfc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module tfc_div #(
  parameter int NB = 50,
  parameter int DB = 33
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NB-1:0] dividend,
  input  wire logic [DB-1:0] divisor,
  output logic               busy,
  output logic [NB-1:0]      quo,
  output logic [DB-1:0]      rem
);

  localparam int CTW = $clog2(NB + 1);

  logic [NB-1:0]  q;
  logic [DB-1:0]  r;
  logic [DB-1:0]  dv;
  logic [CTW-1:0] cnt;
  logic [DB:0]    r2;
  logic           ge;

  assign r2 = {r, q[NB-1]};
  assign ge = r2 >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CTW'(NB);
      q    <= dividend;
      r    <= '0;
      dv   <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      r   <= ge ? DB'(r2 - {1'b0, dv}) : DB'(r2);
      q   <= {q[NB-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = q;
  assign rem = r;

endmodule

`default_nettype wire

>>> hdl/tfc_ctrl.sv
// Sequencer of the transform matrix composer: steps the datapath per operation.
`default_nettype none

module tfc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          out_ready,
  input  wire tfc_pkg::stat_t stat,
  output logic               in_ready,
  output logic               out_valid,
  output tfc_pkg::cmd_t      cmd
);

  tfc_pkg::state_t state, state_next;
  tfc_pkg::rsel_t  rsel, rsel_next;
  tfc_pkg::dsel_t  dsel, dsel_next;
  logic [1:0] i, i_next, j, j_next, k, k_next;
  logic [3:0] e, e_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfc_pkg::S_IDLE;
      rsel  <= tfc_pkg::SEL_Z;
      dsel  <= tfc_pkg::DV_ANGLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      e     <= '0;
    end else begin
      state <= state_next;
      rsel  <= rsel_next;
      dsel  <= dsel_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      e     <= e_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    rsel_next  = rsel;
    dsel_next  = dsel;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    e_next     = e;
    case (state)
      tfc_pkg::S_IDLE: begin
        e_next = '0;
        if (in_valid) begin
          state_next = tfc_pkg::S_DISP;
        end
      end
      tfc_pkg::S_DISP: begin
        i_next = '0;
        j_next = '0;
        k_next = '0;
        if (stat.mode == tfc_pkg::MODE_SCALE || stat.mode == tfc_pkg::MODE_TRANS) begin
          state_next = tfc_pkg::S_MSTART;
        end else if (stat.mode == tfc_pkg::MODE_ROT) begin
          rsel_next  = tfc_pkg::SEL_Z;
          state_next = tfc_pkg::S_MOD;
        end else if (stat.mode == tfc_pkg::MODE_PERSP && !stat.fault) begin
          rsel_next  = tfc_pkg::SEL_P;
          state_next = tfc_pkg::S_MOD;
        end else begin
          state_next = tfc_pkg::S_EMIT;
        end
      end
      tfc_pkg::S_MOD: begin
        state_next = tfc_pkg::S_MODW;
      end
      tfc_pkg::S_MODW: begin
        if (!stat.busy) begin
          state_next = tfc_pkg::S_CORW;
        end
      end
      tfc_pkg::S_CORW: begin
        if (!stat.busy) begin
          if (rsel == tfc_pkg::SEL_P) begin
            dsel_next  = tfc_pkg::DV_TAN;
            state_next = tfc_pkg::S_DGO;
          end else begin
            state_next = tfc_pkg::S_ROTOM;
          end
        end
      end
      tfc_pkg::S_ROTOM: begin
        i_next     = '0;
        j_next     = '0;
        k_next     = '0;
        state_next = tfc_pkg::S_MSTART;
      end
      tfc_pkg::S_DGO: begin
        state_next = tfc_pkg::S_DWAIT;
      end
      tfc_pkg::S_DWAIT: begin
        if (!stat.busy) begin
          if (dsel == tfc_pkg::DV_PERSP) begin
            state_next = tfc_pkg::S_POM;
          end else begin
            dsel_next  = (dsel == tfc_pkg::DV_TAN) ? tfc_pkg::DV_TB : tfc_pkg::DV_PERSP;
            state_next = tfc_pkg::S_DGO;
          end
        end
      end
      tfc_pkg::S_POM: begin
        i_next     = '0;
        j_next     = '0;
        k_next     = '0;
        state_next = tfc_pkg::S_MSTART;
      end
      tfc_pkg::S_MSTART: begin
        state_next = tfc_pkg::S_MULW;
      end
      tfc_pkg::S_MULW: begin
        if (!stat.busy) begin
          if (k == 2'd3) begin
            state_next = tfc_pkg::S_STORE;
          end else begin
            k_next     = k + 2'd1;
            state_next = tfc_pkg::S_MSTART;
          end
        end
      end
      tfc_pkg::S_STORE: begin
        k_next = '0;
        if (i == 2'd3 && j == 2'd3) begin
          state_next = tfc_pkg::S_COPY;
        end else begin
          {i_next, j_next} = {i, j} + 4'd1;
          state_next       = tfc_pkg::S_MSTART;
        end
      end
      tfc_pkg::S_COPY: begin
        if (stat.mode == tfc_pkg::MODE_ROT && rsel != tfc_pkg::SEL_Y) begin
          rsel_next  = (rsel == tfc_pkg::SEL_Z) ? tfc_pkg::SEL_X : tfc_pkg::SEL_Y;
          state_next = tfc_pkg::S_MOD;
        end else begin
          state_next = tfc_pkg::S_EMIT;
        end
      end
      tfc_pkg::S_EMIT: begin
        if (out_ready) begin
          e_next = e + 4'd1;
          if (e == 4'd15) begin
            state_next = tfc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = tfc_pkg::S_IDLE;
      end
    endcase
  end

  // commands and handshake
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.op    = tfc_pkg::OP_NOP;
    cmd.rsel  = rsel;
    cmd.dsel  = dsel;
    cmd.ridx  = {i, k};
    cmd.oidx  = {k, j};
    cmd.widx  = {i, j};
    cmd.clr   = (k == 2'd0);
    case (state)
      tfc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = tfc_pkg::OP_LOAD;
        end
      end
      tfc_pkg::S_DISP: begin
        if (stat.mode == tfc_pkg::MODE_IDENT) begin
          cmd.op = tfc_pkg::OP_IDENT;
        end else if (stat.mode == tfc_pkg::MODE_SCALE) begin
          cmd.op = tfc_pkg::OP_OM_SCALE;
        end else if (stat.mode == tfc_pkg::MODE_TRANS) begin
          cmd.op = tfc_pkg::OP_OM_TRANS;
        end
      end
      tfc_pkg::S_MOD: begin
        cmd.op   = tfc_pkg::OP_DIV_START;
        cmd.dsel = tfc_pkg::DV_ANGLE;
      end
      tfc_pkg::S_MODW: begin
        cmd.dsel = tfc_pkg::DV_ANGLE;
        if (!stat.busy) begin
          cmd.op = tfc_pkg::OP_DIV_SAVE;
        end
      end
      tfc_pkg::S_ROTOM: begin
        cmd.op = tfc_pkg::OP_OM_ROT;
      end
      tfc_pkg::S_DGO: begin
        cmd.op = tfc_pkg::OP_DIV_START;
      end
      tfc_pkg::S_DWAIT: begin
        if (!stat.busy) begin
          cmd.op = tfc_pkg::OP_DIV_SAVE;
        end
      end
      tfc_pkg::S_POM: begin
        cmd.op = tfc_pkg::OP_OM_PERSP;
      end
      tfc_pkg::S_MSTART: begin
        cmd.op = tfc_pkg::OP_MUL_START;
      end
      tfc_pkg::S_STORE: begin
        cmd.op = tfc_pkg::OP_STORE;
      end
      tfc_pkg::S_COPY: begin
        cmd.op = tfc_pkg::OP_COPY;
      end
      tfc_pkg::S_EMIT: begin
        out_valid = 1'b1;
        cmd.ridx  = e;
      end
      default: begin
        cmd.op = tfc_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/tfc_dp.sv
// Datapath: matrix registers, shared multiplier, divider, CORDIC and operand builder.
`default_nettype none

module tfc_dp #(
  parameter int W = tfc_pkg::WORD_BITS_DEF,
  parameter int F = tfc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfc_pkg::cmd_t      cmd,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] op_a,
  input  wire logic signed [31:0] op_b,
  input  wire logic signed [31:0] op_c,
  input  wire logic signed [31:0] op_d,
  output tfc_pkg::stat_t          stat,
  output logic signed [W-1:0]     elem
);

  localparam int HB   = (W + 1) / 2;
  localparam int PW   = 4 * HB;
  localparam int AW   = W + 3;
  localparam int CW   = 34;
  localparam int ZW   = 36;
  localparam int IW   = 49;
  localparam int MAGB = (W + 1 > 33) ? (W + 1) : 33;
  localparam int DVW  = MAGB + 1;
  localparam int DB   = MAGB;
  localparam int NB   = MAGB + F + 1;
  localparam int MW   = ((PW > NB) ? PW : NB) + 1;

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = (F >= W - 1) ? MAXW : W'(1 << F);
  localparam logic signed [W-1:0] NEG1 = (F >= W - 1) ? MINW : W'(-(1 << F));
  localparam logic [63:0] TP64 = (64'd26986075409 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [DB-1:0] TPD = DB'(TP64);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(64'd3373259426);
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(64'd1686629713);
  localparam logic signed [CW-1:0] K_C    = CW'(652032874);

  function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    lim = MW'(MAXW);
    if (m > lim) begin
      return neg ? MINW : MAXW;
    end
    return neg ? W'(MW'(0) - m) : W'(m);
  endfunction

  function automatic logic signed [W-1:0] sat_acc(input logic signed [AW-1:0] v);
    if (v > AW'(MAXW)) return MAXW;
    if (v < AW'(MINW)) return MINW;
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    return (v == MINW) ? MAXW : -v;
  endfunction

  function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] v);
    logic signed [IW-1:0] t;
    t = IW'(v);
    if (t > IW'(MAXW)) return MAXW;
    if (t < IW'(MINW)) return MINW;
    return W'(t);
  endfunction

  function automatic logic signed [W-1:0] from_q30(input logic signed [CW-1:0] v);
    logic [CW-1:0] m;
    logic [MW-1:0] m2;
    m  = v[CW-1] ? CW'(-v) : CW'(v);
    m2 = (MW'(m) + (MW'(1) << (29 - F))) >> (30 - F);
    return from_mag(v[CW-1], m2);
  endfunction

  // operands and matrices
  logic [2:0]          mode_r;
  logic signed [W-1:0] a_r, b_r, c_r, d_r;
  logic                fault_r;
  logic signed [W-1:0] cur [16];
  logic signed [W-1:0] scr [16];
  logic signed [W-1:0] om  [16];

  // multiplier
  logic [W-1:0]         mam, mbm;
  logic                 mneg;
  logic [PW-1:0]        prod;
  logic [2:0]           pc;
  logic                 mbusy;
  logic signed [AW-1:0] acc;
  logic signed [W-1:0]  ma, mb;
  logic [HB-1:0]        pa, pb;
  logic [2*HB-1:0]      pp;
  logic [PW-1:0]        part;
  logic signed [W-1:0]  mprod;

  assign ma    = cur[cmd.ridx];
  assign mb    = om[cmd.oidx];
  assign pa    = pc[1] ? HB'(mam >> HB) : mam[HB-1:0];
  assign pb    = pc[0] ? HB'(mbm >> HB) : mbm[HB-1:0];
  assign pp    = pa * pb;
  assign part  = PW'(pp) << ((pc[1] ? HB : 0) + (pc[0] ? HB : 0));
  assign mprod = from_mag(mneg, (MW'(prod) + (MW'(1) << (F - 1))) >> F);

  // CORDIC
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [4:0]           it;
  logic                 cbusy, flip;
  logic signed [ZW-1:0] at;
  logic signed [CW-1:0] s30, c30;
  logic signed [W-1:0]  sq, cq;

  assign at  = ZW'(tfc_pkg::atan_q30(it));
  assign s30 = flip ? -cy : cy;
  assign c30 = flip ? -cx : cx;
  assign sq  = from_q30(s30);
  assign cq  = from_q30(c30);

  // divider operands and results
  logic signed [W-1:0]   ang;
  logic [W-1:0]          ang_mag;
  logic signed [DVW-1:0] nn, dd;
  logic [DVW-1:0]        un, ud;
  logic [NB-1:0]         div_dvd;
  logic [DB-1:0]         div_dvs;
  logic                  div_start, div_busy;
  logic [NB-1:0]         div_quo;
  logic [DB-1:0]         div_rem;
  logic                  ang_neg, dneg, dz, dnpos, dnzero;
  logic signed [W-1:0]   tq, tbq, pq, fres;
  logic [DB-1:0]         rr;
  logic signed [ZW-1:0]  z0, z1, z2;
  logic                  zflip;

  always_comb begin
    case (cmd.rsel)
      tfc_pkg::SEL_Z: ang = c_r;
      tfc_pkg::SEL_X: ang = a_r;
      tfc_pkg::SEL_Y: ang = b_r;
      default:        ang = a_r >>> 1;
    endcase
    ang_mag = ang[W-1] ? W'(-ang) : W'(ang);
    case (cmd.dsel)
      tfc_pkg::DV_TAN: begin
        nn = DVW'(s30);
        dd = DVW'(c30);
      end
      tfc_pkg::DV_TB: begin
        nn = DVW'(tq);
        dd = DVW'(b_r);
      end
      default: begin
        nn = DVW'(d_r) + DVW'(c_r);
        dd = DVW'(d_r) - DVW'(c_r);
      end
    endcase
    un = nn[DVW-1] ? DVW'(-nn) : DVW'(nn);
    ud = dd[DVW-1] ? DVW'(-dd) : DVW'(dd);
    if (cmd.dsel == tfc_pkg::DV_ANGLE) begin
      div_dvd = NB'(ang_mag);
      div_dvs = TPD;
    end else begin
      div_dvd = NB'(un[DB-1:0]) << (F + 1);
      div_dvs = ud[DB-1:0];
    end
  end

  assign div_start = (cmd.op == tfc_pkg::OP_DIV_START);

  tfc_div #(
    .NB(NB),
    .DB(DB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // rounded quotient, or for a zero divisor the signed limit (zero when the dividend is zero)
  always_comb begin
    if (dz) begin
      fres = dnpos ? MAXW : (dnzero ? '0 : MINW);
    end else begin
      fres = from_mag(dneg, (MW'(div_quo) + MW'(1)) >> 1);
    end
  end

  // angle remainder into Q30, folded into the right half plane
  always_comb begin
    rr    = (ang_neg && div_rem != '0) ? TPD - div_rem : div_rem;
    z0    = ZW'(rr) << (30 - F);
    z1    = (z0 >= PI_Z) ? z0 - (PI_Z <<< 1) : z0;
    z2    = z1;
    zflip = 1'b0;
    if (z1 > HALF_Z) begin
      z2    = z1 - PI_Z;
      zflip = 1'b1;
    end else if (z1 < -HALF_Z) begin
      z2    = z1 + PI_Z;
      zflip = 1'b1;
    end
  end

  // rotation plane indices
  logic [1:0] rp, rq;

  always_comb begin
    case (cmd.rsel)
      tfc_pkg::SEL_Z: begin
        rp = 2'd0;
        rq = 2'd1;
      end
      tfc_pkg::SEL_X: begin
        rp = 2'd1;
        rq = 2'd2;
      end
      default: begin
        rp = 2'd2;
        rq = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      cbusy <= 1'b0;
      pc    <= '0;
      it    <= '0;
      for (int n = 0; n < 16; n++) begin
        cur[n] <= (n % 5 == 0) ? ONE : '0;
      end
    end else begin
      case (cmd.op)
        tfc_pkg::OP_LOAD: begin
          mode_r  <= mode;
          a_r     <= sat_in(op_a);
          b_r     <= sat_in(op_b);
          c_r     <= sat_in(op_c);
          d_r     <= sat_in(op_d);
          fault_r <= (mode == tfc_pkg::MODE_PERSP) &&
                     (sat_in(op_b) == '0 || sat_in(op_d) == sat_in(op_c));
        end
        tfc_pkg::OP_IDENT: begin
          for (int n = 0; n < 16; n++) begin
            cur[n] <= (n % 5 == 0) ? ONE : '0;
          end
        end
        tfc_pkg::OP_OM_SCALE: begin
          for (int n = 0; n < 16; n++) begin
            om[n] <= (n % 5 == 0) ? ONE : '0;
          end
          om[0]  <= a_r;
          om[5]  <= b_r;
          om[10] <= c_r;
        end
        tfc_pkg::OP_OM_TRANS: begin
          for (int n = 0; n < 16; n++) begin
            om[n] <= (n % 5 == 0) ? ONE : '0;
          end
          om[12] <= a_r;
          om[13] <= b_r;
          om[14] <= c_r;
        end
        tfc_pkg::OP_OM_ROT: begin
          for (int n = 0; n < 16; n++) begin
            om[n] <= (n % 5 == 0) ? ONE : '0;
          end
          om[{rp, rp}] <= cq;
          om[{rp, rq}] <= sq;
          om[{rq, rp}] <= neg_sat(sq);
          om[{rq, rq}] <= cq;
        end
        tfc_pkg::OP_OM_PERSP: begin
          for (int n = 0; n < 16; n++) begin
            om[n] <= '0;
          end
          om[0]  <= tbq;
          om[5]  <= tq;
          om[10] <= pq;
          om[14] <= NEG1;
          om[15] <= ONE;
        end
        tfc_pkg::OP_DIV_START: begin
          ang_neg <= ang[W-1];
          dneg    <= nn[DVW-1] ^ dd[DVW-1];
          dz      <= (dd == '0);
          dnpos   <= !nn[DVW-1] && (nn != '0);
          dnzero  <= (nn == '0);
        end
        tfc_pkg::OP_DIV_SAVE: begin
          case (cmd.dsel)
            tfc_pkg::DV_ANGLE: begin
              cz    <= z2;
              flip  <= zflip;
              cx    <= K_C;
              cy    <= '0;
              it    <= '0;
              cbusy <= 1'b1;
            end
            tfc_pkg::DV_TAN: tq  <= fres;
            tfc_pkg::DV_TB:  tbq <= fres;
            default:         pq  <= neg_sat(fres);
          endcase
        end
        tfc_pkg::OP_MUL_START: begin
          mam   <= ma[W-1] ? W'(-ma) : W'(ma);
          mbm   <= mb[W-1] ? W'(-mb) : W'(mb);
          mneg  <= ma[W-1] ^ mb[W-1];
          prod  <= '0;
          pc    <= '0;
          mbusy <= 1'b1;
          if (cmd.clr) begin
            acc <= '0;
          end
        end
        tfc_pkg::OP_STORE: begin
          scr[cmd.widx] <= sat_acc(acc);
        end
        tfc_pkg::OP_COPY: begin
          for (int n = 0; n < 16; n++) begin
            cur[n] <= scr[n];
          end
        end
        default: begin
        end
      endcase

      // four partial products, then round, saturate and accumulate
      if (mbusy) begin
        if (pc != 3'd4) begin
          prod <= prod + part;
          pc   <= pc + 3'd1;
        end else begin
          acc   <= acc + AW'(mprod);
          mbusy <= 1'b0;
        end
      end

      // one CORDIC rotation per cycle
      if (cbusy) begin
        if (!cz[ZW-1]) begin
          cx <= cx - (cy >>> it);
          cy <= cy + (cx >>> it);
          cz <= cz - at;
        end else begin
          cx <= cx + (cy >>> it);
          cy <= cy - (cx >>> it);
          cz <= cz + at;
        end
        it <= it + 5'd1;
        if (it == 5'd29) begin
          cbusy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy  = mbusy | cbusy | div_busy;
  assign stat.fault = fault_r;
  assign stat.mode  = mode_r;
  assign elem       = cur[cmd.ridx];

endmodule

`default_nettype wire

>>> hdl/transform_matrix_composer.sv
// Top level of the transform matrix composer.
`default_nettype none

// The block holds a 4x4 transform matrix in signed fixed point (Q16.16 by
// default) and updates it once per operation word taken on items: load
// identity, scale, rotate (Z, then X, then Y), translate, or perspective. The
// operand matrix is built from the word's operands and multiplied onto the
// right of the stored matrix; every product and every sum of four saturates.
// After each operation the sixteen elements leave on elems in row-major order,
// last marking the final one. A perspective with a zero aspect or with far
// equal to near keeps the matrix and sets fault on all sixteen elements;
// modes 5 to 7 keep the matrix with fault low. One operation word is handled
// at a time, and items stays not ready until the sixteenth element is taken.
// Cost is set by one shared multiplier that works through each product in
// steps (start, four partial products, round and accumulate, handoff), and one
// composition takes 64 products plus 16 stores and the copy back; the angle
// reduction and each quotient use a shared bit-serial divider whose quotient
// has FRAC_BITS+1 bits more than the wider of WORD_BITS+1 and 33 (50 by
// default), and sine/cosine come from the CORDIC. The matrix resets to the
// identity.

module transform_matrix_composer #(
  parameter int WORD_BITS = tfc_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = tfc_pkg::FRAC_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  tfc_in_if.sink    items,
  tfc_out_if.source elems
);

  tfc_pkg::cmd_t               cmd;
  tfc_pkg::stat_t              stat;
  logic signed [WORD_BITS-1:0] elem;
  logic                        in_ready;
  logic                        out_valid;

  // sequencer: walks each operation through the datapath and emits the words
  tfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .out_ready (elems.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: holds the matrix and does all arithmetic
  tfc_dp #(
    .W(WORD_BITS),
    .F(FRAC_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .mode (items.mode),
    .op_a (items.op_a),
    .op_b (items.op_b),
    .op_c (items.op_c),
    .op_d (items.op_d),
    .stat (stat),
    .elem (elem)
  );

  assign items.ready = in_ready;

  // during emission the read index is the element position
  assign elems.valid = out_valid;
  assign elems.row   = cmd.ridx[3:2];
  assign elems.col   = cmd.ridx[1:0];
  assign elems.value = 32'(elem);
  assign elems.last  = &cmd.ridx;
  assign elems.fault = stat.fault;

endmodule

`default_nettype wire
